@@ rtl/dcma_pkg.sv @@
// shared widths, command codes and defaults for the dual channel moving average
`default_nettype none

package dcma_pkg;

  localparam int P_W = 17;        // pressure sample and average width
  localparam int T_W = 11;        // temperature sample and average width
  localparam int FC_W = 5;        // fill count width on the result channel
  localparam int WINDOW_DEF = 20; // default window length

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic [P_W-1:0] pressure_t;
  typedef logic signed [T_W-1:0] temperature_t;
  typedef logic [FC_W-1:0] fill_t;

endpackage

`default_nettype wire

@@ rtl/dcma_if.sv @@
// valid/ready channel interfaces for sample items and average results
`default_nettype none

interface dcma_in_if import dcma_pkg::*; ();
  logic         valid;
  logic         ready;
  logic         cmd;
  pressure_t    pressure_sample;
  temperature_t temperature_sample;

  modport source(output valid, cmd, pressure_sample, temperature_sample, input ready);
  modport sink(input valid, cmd, pressure_sample, temperature_sample, output ready);
endinterface

interface dcma_out_if import dcma_pkg::*; ();
  logic         valid;
  logic         ready;
  pressure_t    pressure_average;
  temperature_t temperature_average;
  fill_t        fill_count;

  modport source(output valid, pressure_average, temperature_average, fill_count,
                 input ready);
  modport sink(input valid, pressure_average, temperature_average, fill_count,
               output ready);
endinterface

`default_nettype wire

@@ rtl/dcma_ring.sv @@
// ring store holding the last window of pressure and temperature samples
`default_nettype none

module dcma_ring import dcma_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_slot,
  input  wire pressure_t         wr_p,
  input  wire temperature_t      wr_t,
  input  wire logic [SLOT_W-1:0] rd_slot,
  output      pressure_t         rd_p,
  output      temperature_t      rd_t
);

  pressure_t    p_mem [WINDOW];
  temperature_t t_mem [WINDOW];
  pressure_t    rd_p_r;
  temperature_t rd_t_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      p_mem[wr_slot] <= wr_p;
      t_mem[wr_slot] <= wr_t;
    end
    rd_p_r <= p_mem[rd_slot];
    rd_t_r <= t_mem[rd_slot];
  end

  assign rd_p = rd_p_r;
  assign rd_t = rd_t_r;

endmodule

`default_nettype wire

@@ rtl/dcma_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module dcma_div import dcma_pkg::*; #(
  parameter int DV_W = 22,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DV_W-1:0]  dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output      logic             done,
  output      logic [DV_W-1:0]  quotient
);

  localparam int IT_W = $clog2(DV_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [IT_W-1:0]  iter_r, iter_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic [DV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_r, quo_r[DV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = IT_W'(DV_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_nxt  = {quo_r[DV_W-2:0], ge};
      iter_nxt = iter_r - IT_W'(1);
      if (iter_r == IT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/dual_channel_moving_average_top.sv @@
// top level of the dual channel boxcar moving average
`default_nettype none

// Keeps the last WINDOW pressure/temperature pairs in a ring store with a running sum
// per channel and returns both window means (truncated toward zero) and the fill
// count for every transfer. For an add transfer both means come out of one bit-serial
// divider that produces one quotient bit per cycle, pressure first, then temperature.
// The input is not ready while an item is in work; a finished result waits in the
// output register while the next item is taken.
module dual_channel_moving_average_top import dcma_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dcma_in_if.sink  in_ch,
  dcma_out_if.source out_ch
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PS_W = P_W + CNT_W;
  localparam int TS_W = T_W + CNT_W;
  localparam int DV_W = PS_W;
  localparam int EXT_W = (CNT_W > FC_W) ? CNT_W : FC_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PWAIT  = 3'd3;
  localparam logic [2:0] S_TSTART = 3'd4;
  localparam logic [2:0] S_TWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [PS_W-1:0]          psum_r, psum_nxt;
  logic signed [TS_W-1:0]   tsum_r, tsum_nxt;
  pressure_t                p_r, p_nxt;
  temperature_t             t_r, t_nxt;
  pressure_t                pavg_r, pavg_nxt;
  temperature_t             tavg_r, tavg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  pressure_t                out_p_r, out_p_nxt;
  temperature_t             out_t_r, out_t_nxt;
  fill_t                    out_fc_r, out_fc_nxt;

  logic                     accept;
  logic                     full;
  logic                     ring_wr;
  pressure_t                rd_p;
  temperature_t             rd_t;
  logic                     div_start;
  logic [DV_W-1:0]          div_dvd;
  logic                     div_done;
  logic [DV_W-1:0]          div_quo;
  logic [TS_W-1:0]          tmag;
  logic [T_W-1:0]           tq;
  logic [EXT_W-1:0]         cnt_ext;

  assign accept  = in_ch.valid && in_ch.ready;
  assign full    = count_r == CNT_W'(WINDOW);
  assign ring_wr = state_r == S_UPD;
  assign tmag    = tsum_r[TS_W-1] ? TS_W'(-tsum_r) : TS_W'(tsum_r);
  assign tq      = div_quo[T_W-1:0];
  assign cnt_ext = EXT_W'(count_r);

  assign div_start = (state_r == S_PSTART) || (state_r == S_TSTART);
  assign div_dvd   = (state_r == S_PSTART) ? psum_r : DV_W'(tmag);

  dcma_ring #(.WINDOW(WINDOW)) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_slot (slot_r),
    .wr_p    (p_r),
    .wr_t    (t_r),
    .rd_slot (slot_r),
    .rd_p    (rd_p),
    .rd_t    (rd_t)
  );

  dcma_div #(.DV_W(DV_W), .CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    psum_nxt      = psum_r;
    tsum_nxt      = tsum_r;
    p_nxt         = p_r;
    t_nxt         = t_r;
    pavg_nxt      = pavg_r;
    tavg_nxt      = tavg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_p_nxt     = out_p_r;
    out_t_nxt     = out_t_r;
    out_fc_nxt    = out_fc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.cmd == CMD_CLEAR) begin
            slot_nxt  = '0;
            count_nxt = '0;
            psum_nxt  = '0;
            tsum_nxt  = '0;
            pavg_nxt  = '0;
            tavg_nxt  = '0;
            state_nxt = S_OUT;
          end else begin
            p_nxt     = in_ch.pressure_sample;
            t_nxt     = in_ch.temperature_sample;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        // ring read data is the entry about to be overwritten
        if (full) begin
          psum_nxt = psum_r + PS_W'(p_r) - PS_W'(rd_p);
          tsum_nxt = tsum_r + TS_W'(t_r) - TS_W'(rd_t);
        end else begin
          psum_nxt  = psum_r + PS_W'(p_r);
          tsum_nxt  = tsum_r + TS_W'(t_r);
          count_nxt = count_r + CNT_W'(1);
        end
        slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        state_nxt = S_PSTART;
      end
      S_PSTART: begin
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_done) begin
          pavg_nxt  = div_quo[P_W-1:0];
          state_nxt = S_TSTART;
        end
      end
      S_TSTART: begin
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_done) begin
          tavg_nxt  = tsum_r[TS_W-1] ? -tq : tq;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_p_nxt     = pavg_r;
          out_t_nxt     = tavg_r;
          out_fc_nxt    = cnt_ext[FC_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      psum_r      <= '0;
      tsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      psum_r      <= psum_nxt;
      tsum_r      <= tsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r      <= p_nxt;
    t_r      <= t_nxt;
    pavg_r   <= pavg_nxt;
    tavg_r   <= tavg_nxt;
    out_p_r  <= out_p_nxt;
    out_t_r  <= out_t_nxt;
    out_fc_r <= out_fc_nxt;
  end

  assign in_ch.ready                = state_r == S_IDLE;
  assign out_ch.valid               = out_valid_r;
  assign out_ch.pressure_average    = out_p_r;
  assign out_ch.temperature_average = out_t_r;
  assign out_ch.fill_count          = out_fc_r;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for the dual channel moving average: directed and random sample streams
module testbench import dcma_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW = WINDOW_DEF;
  localparam int MAX_IDLE = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1070;

  typedef struct packed {
    pressure_t    pressure_average;
    temperature_t temperature_average;
    fill_t        fill_count;
  } averages_t;

  logic clk = 1'b0;
  logic rst_n;

  dcma_in_if  in_ch ();
  dcma_out_if out_ch ();

  dual_channel_moving_average_top #(.WINDOW(WINDOW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5ns clk = ~clk;

  // window predictor state
  pressure_t    press_window [WINDOW];
  temperature_t temp_window  [WINDOW];
  int           next_slot = 0;
  int           held_pairs = 0;
  longint       press_sum = 0;
  longint       temp_sum = 0;

  averages_t pending_averages [$];

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int errors = 0;
  int add_count = 0;
  int clear_count = 0;
  int results_checked = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // updates the window on an accepted transfer and queues the averages it yields
  function automatic void predict_averages(logic cmd, pressure_t p, temperature_t t);
    averages_t want;
    longint press_avg;
    longint temp_mean;
    if (cmd == CMD_CLEAR) begin
      next_slot = 0;
      held_pairs = 0;
      press_sum = 0;
      temp_sum = 0;
    end else begin
      if (held_pairs < WINDOW) begin
        held_pairs++;
      end else begin
        // window full: oldest pair drops out
        press_sum -= press_window[next_slot];
        temp_sum -= temp_window[next_slot];
      end
      press_sum += p;
      temp_sum += t;
      press_window[next_slot] = p;
      temp_window[next_slot] = t;
      next_slot = (next_slot + 1) % WINDOW;
    end
    press_avg = 0;
    temp_mean = 0;
    if (held_pairs > 0) begin
      press_avg = press_sum / held_pairs;
      temp_mean = temp_sum / held_pairs; // truncates toward zero
    end
    want.pressure_average = pressure_t'(press_avg);
    want.temperature_average = temperature_t'(temp_mean);
    want.fill_count = fill_t'(held_pairs);
    pending_averages.push_back(want);
  endfunction

  function automatic pressure_t rand_pressure();
    case ($urandom_range(0, 3))
      0: return pressure_t'($urandom_range(0, 15));
      1: return pressure_t'($urandom_range(131000, 131071));
      default: return pressure_t'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic temperature_t rand_temperature();
    int v;
    // mostly the sensor range, now and then any 11-bit code
    if ($urandom_range(0, 9) == 0) return temperature_t'($urandom);
    v = $urandom_range(0, 1250);
    return temperature_t'(v - 400);
  endfunction

  // offers one item and returns at the edge where it transfers; valid stays high
  // for a back-to-back item
  task automatic send_item(logic cmd, pressure_t p, temperature_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.pressure_sample <= p;
    in_ch.temperature_sample <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_averages(cmd, p, t);
    if (cmd == CMD_CLEAR) clear_count++;
    else add_count++;
  endtask

  task automatic test_extremes();
    send_item(CMD_CLEAR, '0, '0);                      // empty window
    send_item(CMD_ADD, 17'h1FFFF, 11'sd1023);
    send_item(CMD_ADD, '0, -11'sd1024);
    send_item(CMD_ADD, 17'd1, -11'sd1);
    send_item(CMD_CLEAR, rand_pressure(), rand_temperature()); // mid-window clear
  endtask

  // fills the window from empty with near full-scale pressures and mixed temperatures and wraps past it
  task automatic test_full_window();
    temperature_t t;
    for (int i = 0; i < WINDOW + 2; i++) begin
      case (i % 4)
        0: t = -11'sd1024;
        1: t = 11'sd850;
        2: t = -11'sd400;
        default: t = 11'sd1023;
      endcase
      send_item(CMD_ADD, 17'h1FFFF - pressure_t'(i % 2), t);
    end
  endtask

  // receiver stops for a long stretch so the block backs up into its input
  task automatic test_output_stall();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_item(CMD_ADD, rand_pressure(), rand_temperature());
  endtask

  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 39) == 0) send_item(CMD_CLEAR, rand_pressure(), rand_temperature());
      else send_item(CMD_ADD, rand_pressure(), rand_temperature());
    end
  endtask

  // result side: random stalls, plus the long hold when asked
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // result checking and stall watchdog
  always @(posedge clk) begin
    averages_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_averages.size() == 0) begin
          report_mismatch("result transfer with no expected averages waiting");
        end else begin
          want = pending_averages.pop_front();
          results_checked++;
          if (out_ch.pressure_average !== want.pressure_average)
            report_mismatch($sformatf("pressure_average %0d, expected %0d",
                                      out_ch.pressure_average, want.pressure_average));
          if (out_ch.temperature_average !== want.temperature_average)
            report_mismatch($sformatf("temperature_average %0d, expected %0d",
                                      out_ch.temperature_average, want.temperature_average));
          if (out_ch.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count %0d, expected %0d",
                                      out_ch.fill_count, want.fill_count));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_averages.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_ADD;
    in_ch.pressure_sample <= '0;
    in_ch.temperature_sample <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_full_window();
    test_output_stall();
    test_random_stream();

    in_ch.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d add and %0d clear transfers, %0d result transfers compared",
             add_count, clear_count, results_checked);
    $display("including full-scale window wrap, clears mid-window and a long output hold");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dcma_pkg.sv
rtl/dcma_if.sv
rtl/dcma_ring.sv
rtl/dcma_div.sv
rtl/dual_channel_moving_average_top.sv
tb/testbench.sv
